### rtl/core/oad_pkg.sv
// Shared types and constants for the open addressing dictionary unit.
package oad_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_SEARCH   = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;

    localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [1:0] CFG_STEP_PRIME = 2'd2;

    localparam int HASH_SHIFT = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_PSTEP,
        S_READ,
        S_CHECK,
        S_INS_START,
        S_INS_READ,
        S_INS_CHECK,
        S_WRITE,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

### rtl/core/oad_ram.sv
// Generic single-port RAM with registered read.
module oad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/open_addressing_dictionary_unit.sv
// Top level of the open addressing dictionary unit.
//
// Usage: one request on the s_ channel is an insert, search or delete of a
// key of up to KEY_CHARS packed characters (first character in the top byte)
// with three handles. One response per request leaves on the m_ channel.
// Configuration (table size, probe mode, step prime) is written through
// cfg_we/cfg_index/cfg_data while the unit is idle; the user is bound to
// this, and the unit itself does not enforce it.
// Steps: the key characters are hashed, then h mod p is reduced by repeated
// subtraction, then each walk takes a setup state and, per probe, a memory
// read and a compare; an insert that places walks the sequence twice and
// adds a write. m_valid is registered from the done state after the walk.
// Long probe runs and a small step prime lengthen a request. The single
// slot memory port sets the cost.
// A new request is taken only after the previous response was accepted.
// Reset: synchronous, active low. After reset a clearing pass walks all
// TABLE_DEPTH entries of the used-flag memory, one per cycle, during which
// s_ready stays low; configuration writes are still taken.
// Stall: the response is held in output registers until m_ready is high.
module open_addressing_dictionary_unit #(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_CHARS   = 8,
    parameter int HANDLE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_opcode,
    input  logic [63:0]            s_key_chars,
    input  logic [3:0]             s_key_length,
    input  logic [HANDLE_BITS-1:0] s_meaning_one,
    input  logic [HANDLE_BITS-1:0] s_meaning_two,
    input  logic [HANDLE_BITS-1:0] s_meaning_three,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [6:0]             m_slot_index,
    output logic [7:0]             m_probe_count,
    output logic [31:0]            m_found_one,
    output logic [31:0]            m_found_two,
    output logic [31:0]            m_found_three,
    output logic [15:0]            m_collision_total
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;               // holds TABLE_DEPTH itself
    localparam int CW = $clog2(KEY_CHARS + 1);
    localparam int DW = 64 + 4 + 3 * HANDLE_BITS;

    // configuration
    logic [7:0] table_size_reg;
    logic       probe_mode_reg;
    logic [6:0] step_prime_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= 8'd127;
            probe_mode_reg <= 1'b0;
            step_prime_reg <= 7'd113;
        end else if (cfg_we) begin
            unique case (cfg_index)
                oad_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                oad_pkg::CFG_PROBE_MODE: probe_mode_reg <= cfg_data[0];
                oad_pkg::CFG_STEP_PRIME: step_prime_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // effective size and prime
    logic [SW-1:0] eff_size;
    logic [6:0]    eff_prime;
    always_comb begin
        if (table_size_reg < 8'd2)
            eff_size = SW'(2);
        else if (32'(table_size_reg) > TABLE_DEPTH)
            eff_size = SW'(TABLE_DEPTH);
        else
            eff_size = SW'(table_size_reg);
        eff_prime = (step_prime_reg < 7'd2) ? 7'd2 : step_prime_reg;
    end

    oad_pkg::state_t state_reg, state_next;

    logic [1:0]             op_reg;
    logic [63:0]            key_reg;
    logic [3:0]             len_reg;
    logic [HANDLE_BITS-1:0] m1_reg, m2_reg, m3_reg;
    logic [CW-1:0]          cidx_reg, cidx_next;
    logic [SW-1:0]          h_reg, h_next;
    logic [SW-1:0]          pos_reg, pos_next;   // current probe slot
    logic [SW-1:0]          inc_reg, inc_next;   // increment to next slot
    logic [SW-1:0]          stride_reg, stride_next;
    logic [SW:0]            i_reg, i_next;       // probe number
    logic [AW:0]            clr_reg, clr_next;
    logic [15:0]            coll_reg, coll_next;

    logic [2:0]  st_reg, st_next;
    logic [6:0]  sl_reg, sl_next;
    logic [7:0]  pc_reg, pc_next;
    logic [31:0] f1_reg, f1_next, f2_reg, f2_next, f3_reg, f3_next;
    logic        mv_reg, mv_next;

    // memories: used flags and entry payload
    logic          used_we, used_wd, used_rd;
    logic [AW-1:0] mem_addr;
    logic          data_we;
    logic [DW-1:0] data_wd, data_rd;

    oad_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
        .aclk(aclk), .we(used_we), .addr(mem_addr), .wdata(used_wd), .rdata(used_rd)
    );
    oad_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data (
        .aclk(aclk), .we(data_we), .addr(mem_addr), .wdata(data_wd), .rdata(data_rd)
    );

    logic [63:0]            rd_key;
    logic [3:0]             rd_len;
    logic [HANDLE_BITS-1:0] rd_h1, rd_h2, rd_h3;
    assign {rd_key, rd_len, rd_h1, rd_h2, rd_h3} = data_rd;
    assign data_wd = {key_reg, len_reg, m1_reg, m2_reg, m3_reg};

    // input key masking
    logic [3:0]  in_len;
    logic [63:0] in_key;
    always_comb begin
        in_len = (32'(s_key_length) > KEY_CHARS) ? 4'(KEY_CHARS) : s_key_length;
        in_key = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < 32'(in_len))
                in_key[63-8*k -: 8] = s_key_chars[63-8*k -: 8];
        end
    end

    // one hash character: ((h << 5) + c) mod S, with h < S <= TABLE_DEPTH.
    // The sum is below 32*S + 256, which is below 256*S for S >= 2, so
    // reduce by repeated compare-subtract over binary multiples of S
    // (eight steps).
    logic [7:0]    hash_c;
    logic [SW+6:0] hash_sum;
    logic [SW-1:0] hash_mod;
    always_comb begin
        hash_c   = key_reg[63 - 8*3'(cidx_reg) -: 8];
        hash_sum = ((SW+7)'(h_reg) << oad_pkg::HASH_SHIFT) + (SW+7)'(hash_c);
        for (int b = 7; b >= 0; b--) begin
            if (hash_sum >= ((SW+7)'(eff_size) << b))
                hash_sum = hash_sum - ((SW+7)'(eff_size) << b);
        end
        hash_mod = hash_sum[SW-1:0];
    end

    // double-hash stride p - (h mod p); h < S, p >= 2: done during the
    // hash phase end by compare-subtract in S_PSTEP loop (stride_reg holds h
    // being reduced).
    logic [SW-1:0] pos_add;
    logic [SW:0]   pos_sum;
    always_comb begin
        pos_sum = (SW+1)'(pos_reg) + (SW+1)'(inc_reg);
        if (pos_sum >= (SW+1)'(eff_size))
            pos_sum = pos_sum - (SW+1)'(eff_size);
        pos_add = pos_sum[SW-1:0];
    end

    logic key_match;
    assign key_match = (rd_len == len_reg) && (rd_key == key_reg);

    // next increment: quadratic 2i+1 mod S, double a constant stride
    logic [SW:0]   q_inc;
    logic [SW-1:0] inc_upd;
    always_comb begin
        q_inc = (SW+1)'(inc_reg) + (SW+1)'(2);
        if (q_inc >= (SW+1)'(eff_size))
            q_inc = q_inc - (SW+1)'(eff_size);
        inc_upd = probe_mode_reg ? inc_reg : q_inc[SW-1:0];
    end

    // stride init mod S (stride <= 127, S >= 2)
    logic [SW:0] stride_mod;
    always_comb begin
        stride_mod = (SW+1)'(stride_reg);
        for (int b = 6; b >= 0; b--) begin
            if (stride_mod >= ((SW+1)'(eff_size) << b))
                stride_mod = stride_mod - ((SW+1)'(eff_size) << b);
        end
    end

    logic [SW:0] size_ext;
    assign size_ext = (SW+1)'(eff_size);

    always_comb begin
        state_next  = state_reg;
        cidx_next   = cidx_reg;
        h_next      = h_reg;
        pos_next    = pos_reg;
        inc_next    = inc_reg;
        stride_next = stride_reg;
        i_next      = i_reg;
        clr_next    = clr_reg;
        coll_next   = coll_reg;
        st_next = st_reg; sl_next = sl_reg; pc_next = pc_reg;
        f1_next = f1_reg; f2_next = f2_reg; f3_next = f3_reg;
        mv_next = mv_reg;
        used_we  = 1'b0;
        used_wd  = 1'b0;
        data_we  = 1'b0;
        mem_addr = pos_reg[AW-1:0];
        s_ready  = 1'b0;

        unique case (state_reg)
            oad_pkg::S_CLEAR: begin
                // sweep the used flags to empty
                used_we  = 1'b1;
                mem_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(TABLE_DEPTH - 1))
                    state_next = oad_pkg::S_IDLE;
            end
            oad_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cidx_next  = '0;
                    h_next     = '0;
                    if (s_opcode == oad_pkg::OP_RESERVED) begin
                        // unknown opcode: answer not found without a walk
                        st_next = oad_pkg::ST_NOT_FOUND; sl_next = '0; pc_next = '0;
                        f1_next = '0; f2_next = '0; f3_next = '0;
                        state_next = oad_pkg::S_DONE;
                    end else begin
                        state_next = oad_pkg::S_HASH;
                    end
                end
            end
            oad_pkg::S_HASH: begin
                if (32'(cidx_reg) < 32'(len_reg)) begin
                    h_next    = hash_mod;
                    cidx_next = cidx_reg + 1'b1;
                end else begin
                    // start h mod p reduction
                    stride_next = h_reg;
                    state_next  = oad_pkg::S_PSTEP;
                end
            end
            oad_pkg::S_PSTEP: begin
                // reduce h mod p one subtract per cycle (h < S)
                if (stride_reg >= SW'(eff_prime)) begin
                    stride_next = stride_reg - SW'(eff_prime);
                end else begin
                    stride_next = SW'(eff_prime) - stride_reg;
                    state_next  = oad_pkg::S_INS_START;  // reuse: set up walk
                    cidx_next   = '0;
                end
            end
            oad_pkg::S_INS_START: begin
                // begin a walk; cidx_reg[0] marks the insert placement pass
                pos_next = h_reg;
                inc_next = probe_mode_reg ? stride_mod[SW-1:0]
                                          : ((eff_size == SW'(1)) ? '0 : SW'(1));
                i_next   = '0;
                state_next = (cidx_reg == '0) ? oad_pkg::S_READ : oad_pkg::S_INS_READ;
            end
            oad_pkg::S_READ: begin
                if (i_reg >= size_ext) begin
                    if (op_reg == oad_pkg::OP_INSERT) begin
                        cidx_next  = CW'(1);
                        state_next = oad_pkg::S_INS_START;
                    end else begin
                        st_next = oad_pkg::ST_NOT_FOUND; sl_next = '0;
                        pc_next = (i_reg > (SW+1)'(255)) ? 8'd255 : 8'(i_reg);
                        f1_next = '0; f2_next = '0; f3_next = '0;
                        state_next = oad_pkg::S_DONE;
                    end
                end else begin
                    state_next = oad_pkg::S_CHECK;
                end
            end
            oad_pkg::S_CHECK: begin
                if (!used_rd) begin
                    if (op_reg == oad_pkg::OP_INSERT) begin
                        cidx_next  = CW'(1);
                        state_next = oad_pkg::S_INS_START;
                    end else begin
                        st_next = oad_pkg::ST_NOT_FOUND; sl_next = '0;
                        pc_next = (i_reg > (SW+1)'(255)) ? 8'd255 : 8'(i_reg);
                        f1_next = '0; f2_next = '0; f3_next = '0;
                        state_next = oad_pkg::S_DONE;
                    end
                end else if (key_match) begin
                    pc_next = (i_reg > (SW+1)'(255)) ? 8'd255 : 8'(i_reg);
                    if (op_reg == oad_pkg::OP_INSERT) begin
                        st_next = oad_pkg::ST_DUPLICATE; sl_next = '0;
                        f1_next = '0; f2_next = '0; f3_next = '0;
                        state_next = oad_pkg::S_DONE;
                    end else begin
                        sl_next = 7'(pos_reg);
                        f1_next = 32'(rd_h1); f2_next = 32'(rd_h2); f3_next = 32'(rd_h3);
                        if (op_reg == oad_pkg::OP_DELETE) begin
                            st_next = oad_pkg::ST_DELETED;
                            used_we = 1'b1;
                            used_wd = 1'b0;
                        end else begin
                            st_next = oad_pkg::ST_FOUND;
                        end
                        state_next = oad_pkg::S_DONE;
                    end
                end else begin
                    pos_next = pos_add;
                    inc_next = inc_upd;
                    i_next   = i_reg + 1'b1;
                    state_next = oad_pkg::S_READ;
                end
            end
            oad_pkg::S_INS_READ: begin
                if (i_reg >= size_ext) begin
                    st_next = oad_pkg::ST_FULL; sl_next = '0;
                    pc_next = (size_ext > (SW+1)'(255)) ? 8'd255 : 8'(size_ext);
                    f1_next = '0; f2_next = '0; f3_next = '0;
                    state_next = oad_pkg::S_DONE;
                end else begin
                    state_next = oad_pkg::S_INS_CHECK;
                end
            end
            oad_pkg::S_INS_CHECK: begin
                if (!used_rd) begin
                    state_next = oad_pkg::S_WRITE;
                end else begin
                    if (coll_reg != 16'hFFFF)
                        coll_next = coll_reg + 16'd1;
                    pos_next = pos_add;
                    inc_next = inc_upd;
                    i_next   = i_reg + 1'b1;
                    state_next = oad_pkg::S_INS_READ;
                end
            end
            oad_pkg::S_WRITE: begin
                used_we = 1'b1;
                used_wd = 1'b1;
                data_we = 1'b1;
                st_next = oad_pkg::ST_INSERTED;
                sl_next = 7'(pos_reg);
                pc_next = (i_reg > (SW+1)'(255)) ? 8'd255 : 8'(i_reg);
                f1_next = '0; f2_next = '0; f3_next = '0;
                state_next = oad_pkg::S_DONE;
            end
            oad_pkg::S_DONE: begin
                // hold the response until taken
                mv_next = 1'b1;
                if (mv_reg && m_ready) begin
                    mv_next    = 1'b0;
                    state_next = oad_pkg::S_IDLE;
                end
            end
            default: state_next = oad_pkg::S_IDLE;
        endcase
    end

    // state, clearing counter, collision counter and response valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oad_pkg::S_CLEAR;
            clr_reg   <= '0;
            coll_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            coll_reg  <= coll_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        cidx_reg   <= cidx_next;
        h_reg      <= h_next;
        pos_reg    <= pos_next;
        inc_reg    <= inc_next;
        stride_reg <= stride_next;
        i_reg      <= i_next;
        st_reg <= st_next; sl_reg <= sl_next; pc_reg <= pc_next;
        f1_reg <= f1_next; f2_reg <= f2_next; f3_reg <= f3_next;
        if (state_reg == oad_pkg::S_IDLE && s_valid) begin
            op_reg  <= s_opcode;
            key_reg <= in_key;
            len_reg <= in_len;
            m1_reg  <= s_meaning_one;
            m2_reg  <= s_meaning_two;
            m3_reg  <= s_meaning_three;
        end
    end

    assign m_valid           = mv_reg;
    assign m_status          = st_reg;
    assign m_slot_index      = sl_reg;
    assign m_probe_count     = pc_reg;
    assign m_found_one       = f1_reg;
    assign m_found_two       = f2_reg;
    assign m_found_three     = f3_reg;
    assign m_collision_total = coll_reg;

    // response only while in the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == oad_pkg::S_DONE)
        else $error("response valid outside done state");
    // no request taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == oad_pkg::S_CLEAR |-> !s_ready)
        else $error("request taken while clearing");
    // collision counter never decreases
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> coll_reg >= $past(coll_reg))
        else $error("collision counter went down");
    // probe position stays inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == oad_pkg::S_CHECK |-> pos_reg < eff_size)
        else $error("probe outside table");
endmodule

### tb/open_addressing_dictionary_unit_test.sv
// Self-checking testbench for the open addressing dictionary unit.
module open_addressing_dictionary_unit_test;

    localparam int DEPTH     = 128;
    localparam int MAX_IDLE  = 13;
    localparam int QUIET_MAX = 20000;

    typedef struct {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] m1, m2, m3;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [6:0]  slot;
        logic [7:0]  probes;
        logic [31:0] f1, f2, f3;
        logic [15:0] coll;
    } response_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [63:0] s_key_chars;
    logic [3:0]  s_key_length;
    logic [31:0] s_meaning_one, s_meaning_two, s_meaning_three;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [6:0]  m_slot_index;
    logic [7:0]  m_probe_count;
    logic [31:0] m_found_one, m_found_two, m_found_three;
    logic [15:0] m_collision_total;

    open_addressing_dictionary_unit DUT (.*);

    // Shadow copy of the dictionary.
    logic        tbl_used [DEPTH];
    logic [63:0] tbl_key  [DEPTH];
    logic [3:0]  tbl_len  [DEPTH];
    logic [31:0] tbl_h1   [DEPTH], tbl_h2 [DEPTH], tbl_h3 [DEPTH];
    logic [15:0] coll_count;
    logic [7:0]  cfg_size;
    logic        cfg_double;
    logic [6:0]  cfg_prime;

    request_t  pending_requests[$];
    response_t expected_responses[$];
    int        error_count;
    int        sent_count, recv_count;
    int        quiet_cycles;
    bit        hold_off_req;
    bit        stim_done;
    logic [63:0] used_keys[$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int eff_size();
        if (cfg_size < 2) return 2;
        if (cfg_size > DEPTH) return DEPTH;
        return int'(cfg_size);
    endfunction

    function automatic int probe_slot(int h, int i, int s);
        int p;
        p = (cfg_prime < 2) ? 2 : int'(cfg_prime);
        if (cfg_double) return (h + i * (p - (h % p))) % s;
        return (h + i * i) % s;
    endfunction

    // Compute the expected response and update the shadow table.
    function automatic response_t dictionary_apply(request_t r);
        response_t  rsp;
        int         s, h, len, i, q, hit, steps;
        logic [63:0] key;
        s = eff_size();
        len = (r.len > 8) ? 8 : int'(r.len);
        key = (len == 0) ? 64'd0 : r.key & ({64{1'b1}} << (64 - 8 * len));
        h = 0;
        for (int k = 0; k < len; k++) h = ((h << 5) + int'(key[63 - 8 * k -: 8])) % s;
        rsp = '{oad_pkg::ST_NOT_FOUND, 7'd0, 8'd0, 32'd0, 32'd0, 32'd0, 16'd0};
        hit = -1;
        steps = 0;
        if (r.opcode != oad_pkg::OP_RESERVED) begin
            for (i = 0; i < s; i++) begin
                q = probe_slot(h, i, s);
                if (!tbl_used[q]) break;
                if (tbl_len[q] == 4'(len) && tbl_key[q] == key) begin
                    hit = q;
                    break;
                end
            end
            steps = i;
        end
        if (r.opcode == oad_pkg::OP_INSERT) begin
            if (hit >= 0) rsp.status = oad_pkg::ST_DUPLICATE;
            else begin
                rsp.status = oad_pkg::ST_FULL;
                steps = s;
                for (i = 0; i < s; i++) begin
                    q = probe_slot(h, i, s);
                    if (!tbl_used[q]) begin
                        tbl_used[q] = 1'b1;
                        tbl_key[q] = key;
                        tbl_len[q] = 4'(len);
                        tbl_h1[q] = r.m1;
                        tbl_h2[q] = r.m2;
                        tbl_h3[q] = r.m3;
                        rsp.status = oad_pkg::ST_INSERTED;
                        rsp.slot = 7'(q);
                        steps = i;
                        break;
                    end
                    if (coll_count != 16'hFFFF) coll_count++;
                end
            end
        end else if ((r.opcode == oad_pkg::OP_SEARCH || r.opcode == oad_pkg::OP_DELETE)
                     && hit >= 0) begin
            rsp.slot = 7'(hit);
            rsp.f1 = tbl_h1[hit];
            rsp.f2 = tbl_h2[hit];
            rsp.f3 = tbl_h3[hit];
            if (r.opcode == oad_pkg::OP_DELETE) begin
                tbl_used[hit] = 1'b0;
                rsp.status = oad_pkg::ST_DELETED;
            end else rsp.status = oad_pkg::ST_FOUND;
        end
        rsp.probes = (steps > 255) ? 8'd255 : 8'(steps);
        rsp.coll = coll_count;
        return rsp;
    endfunction

    // Driver: present queued requests with random gaps.
    int send_gap;
    logic s_accept, m_accept;
    always @(posedge aclk) begin
        s_accept <= aresetn && s_valid && s_ready;
        m_accept <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_responses.push_back(dictionary_apply(pending_requests.pop_front()));
            sent_count <= sent_count + 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, MAX_IDLE);
        end else if (s_valid && !s_accept) begin
            // hold the request until it is taken
        end else if (s_accept) begin
            s_valid <= 1'b0;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
        end else if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_requests.size() > 0) begin
            s_valid <= 1'b1;
            s_opcode <= pending_requests[0].opcode;
            s_key_chars <= pending_requests[0].key;
            s_key_length <= pending_requests[0].len;
            s_meaning_one <= pending_requests[0].m1;
            s_meaning_two <= pending_requests[0].m2;
            s_meaning_three <= pending_requests[0].m3;
        end
    end

    // Monitor: draw a stall per response, compare at the rising edge.
    int recv_gap;
    int hold_cycles;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
        end else if (hold_off_req && hold_cycles == 0) begin
            m_ready <= 1'b0;
            hold_cycles <= 300;
        end else if (hold_cycles > 1) begin
            hold_cycles <= hold_cycles - 1;
        end else if (m_accept || hold_cycles == 1) begin
            hold_cycles <= 0;
            if (m_accept) begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
                m_ready <= 1'b0;
            end
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        response_t e;
        if (aresetn && m_valid && m_ready) begin
            recv_count <= recv_count + 1;
            if (expected_responses.size() == 0) begin
                $error("response with nothing expected");
                error_count++;
            end else begin
                e = expected_responses.pop_front();
                if (m_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_status); error_count++;
                end
                if (m_slot_index !== e.slot) begin
                    $error("slot_index exp %0d got %0d", e.slot, m_slot_index); error_count++;
                end
                if (m_probe_count !== e.probes) begin
                    $error("probe_count exp %0d got %0d", e.probes, m_probe_count);
                    error_count++;
                end
                if (m_found_one !== e.f1) begin
                    $error("found_one exp %h got %h", e.f1, m_found_one); error_count++;
                end
                if (m_found_two !== e.f2) begin
                    $error("found_two exp %h got %h", e.f2, m_found_two); error_count++;
                end
                if (m_found_three !== e.f3) begin
                    $error("found_three exp %h got %h", e.f3, m_found_three); error_count++;
                end
                if (m_collision_total !== e.coll) begin
                    $error("collision_total exp %0d got %0d", e.coll, m_collision_total);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else if (!stim_done) quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("watchdog expired, %0d responses outstanding", expected_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic request_t make_request(logic [1:0] op, logic [63:0] key, logic [3:0] len);
        request_t r;
        r.opcode = op;
        r.key = key;
        r.len = len;
        r.m1 = $urandom;
        r.m2 = $urandom;
        r.m3 = $urandom;
        return r;
    endfunction

    // Random key drawn mostly from a small pool so hits are common.
    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1)) k = k & 64'h0707070707070707;
        if (used_keys.size() < 40) used_keys.push_back(k);
        return k;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == oad_pkg::CFG_TABLE_SIZE) cfg_size = val;
        else if (idx == oad_pkg::CFG_PROBE_MODE) cfg_double = val[0];
        else if (idx == oad_pkg::CFG_STEP_PRIME) cfg_prime = val[6:0];
    endtask

    // Wait until every response has come back, then let the unit settle.
    task automatic drain();
        while (pending_requests.size() > 0 || expected_responses.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_burst(int count);
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 9) < 5) ? oad_pkg::OP_INSERT : 2'($urandom_range(1, 3));
            pending_requests.push_back(make_request(op, pick_key(), 4'($urandom_range(0, 15))));
        end
    endtask

    // Settings: size, mode, prime.
    int phase_size [6] = '{127, 2, 128, 13, 255, 0};
    int phase_mode [6] = '{0, 1, 1, 0, 1, 1};
    int phase_prime[6] = '{113, 0, 127, 11, 2, 7};

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = oad_pkg::CFG_TABLE_SIZE;
        cfg_data = 8'd0;
        s_valid = 1'b0;
        s_opcode = oad_pkg::OP_INSERT;
        s_key_chars = 64'd0;
        s_key_length = 4'd1;
        s_meaning_one = 32'd0;
        s_meaning_two = 32'd0;
        s_meaning_three = 32'd0;
        m_ready = 1'b0;
        error_count = 0;
        sent_count = 0;
        recv_count = 0;
        quiet_cycles = 0;
        hold_off_req = 1'b0;
        stim_done = 1'b0;
        s_accept = 1'b0;
        m_accept = 1'b0;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        coll_count = 16'd0;
        cfg_size = 8'd127;
        cfg_double = 1'b0;
        cfg_prime = 7'd113;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, every opcode, odd lengths, duplicates.
        pending_requests.push_back(make_request(oad_pkg::OP_INSERT,
                                                64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
        pending_requests.push_back(make_request(oad_pkg::OP_INSERT,
                                                64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH,
                                                64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
        pending_requests.push_back(make_request(oad_pkg::OP_INSERT, 64'd0, 4'd0));
        pending_requests.push_back(make_request(oad_pkg::OP_INSERT,
                                                64'h0000_0000_0000_0001, 4'd15));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH, 64'd0, 4'd0));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH,
                                                64'h00FF_0000_0000_0000, 4'd1));
        pending_requests.push_back(make_request(oad_pkg::OP_INSERT,
                                                64'h4100_0000_0000_0000, 4'd2));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH,
                                                64'h41AA_0000_0000_0000, 4'd1));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH,
                                                64'h4100_7777_0000_0000, 4'd2));
        pending_requests.push_back(make_request(oad_pkg::OP_DELETE,
                                                64'h4100_0000_0000_0000, 4'd2));
        pending_requests.push_back(make_request(oad_pkg::OP_DELETE,
                                                64'h4100_0000_0000_0000, 4'd2));
        pending_requests.push_back(make_request(oad_pkg::OP_RESERVED,
                                                64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
        pending_requests.push_back(make_request(oad_pkg::OP_SEARCH,
                                                64'hFFFF_FFFF_FFFF_FFFF, 4'd9));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(oad_pkg::CFG_TABLE_SIZE, 8'(phase_size[ph]));
            write_reg(oad_pkg::CFG_PROBE_MODE, 8'(phase_mode[ph]));
            write_reg(oad_pkg::CFG_STEP_PRIME, 8'(phase_prime[ph]));
            used_keys.delete();
            // Small tables fill quickly: exercises full and probe wrap.
            random_burst(130);
            if (ph == 2) hold_off_req = 1'b1;
            repeat (2) @(posedge aclk);
            hold_off_req = 1'b0;
            drain();
        end
        stim_done = 1'b1;
        $display("ran %0d requests over six table settings, %0d responses checked",
                 sent_count, recv_count);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/oad_pkg.sv
rtl/core/oad_ram.sv
rtl/core/open_addressing_dictionary_unit.sv
tb/open_addressing_dictionary_unit_test.sv
